FILE: rtl/core/quaternion_to_euler_macros.svh
// Assertion macros for the quaternion to Euler angle block.
// Used by the port checker; relies on clk and rst_n in the including scope.
`ifndef QUATERNION_TO_EULER_MACROS_SVH
`define QUATERNION_TO_EULER_MACROS_SVH

// Condition must hold at every clock edge out of reset
`define QTE_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("check failed");

// Implication checked on the following edge
`define QTE_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

FILE: rtl/core/qte_pkg.sv
// Shared types and constants for the quaternion to Euler angle block.
// No dependencies; used by qte_front, qte_isqrt, qte_cordic and quaternion_to_euler.
package qte_pkg;

    localparam int CW       = 38;  // CORDIC x/y datapath width
    localparam int ZW       = 34;  // CORDIC angle accumulator, pi = 2^31
    localparam int ANG_W    = 18;  // rounded angle before wrap, pi = 2^15
    localparam int ATAN_LEN = 24;  // entries in the arctangent table
    localparam int SQ_STEPS = 31;  // root bits of floor(sqrt(v)), v <= 2^60
    localparam int RW       = 61;  // radicand width
    localparam int OPW      = 33;  // roll/yaw operand width
    localparam int AW       = 32;  // clamped sine term width

    localparam logic signed [ANG_W-1:0] PITCH_MAX = ANG_W'(16384);
    localparam logic signed [ANG_W-1:0] PITCH_MIN = -ANG_W'(16384);

    // Operands carried alongside the square root
    typedef struct packed {
        logic signed [OPW-1:0] roll_y;
        logic signed [OPW-1:0] roll_x;
        logic signed [OPW-1:0] yaw_y;
        logic signed [OPW-1:0] yaw_x;
        logic signed [AW-1:0]  sin_a;
        logic                  clamped;
    } qte_side_t;

    // atan(2^-i) with pi = 2^31
    function automatic logic signed [ZW-1:0] atan_ang(input logic [4:0] i);
        logic signed [ZW-1:0] r;
        unique case (i)
            5'd0:    r = ZW'(536870912);
            5'd1:    r = ZW'(316933406);
            5'd2:    r = ZW'(167458907);
            5'd3:    r = ZW'(85004756);
            5'd4:    r = ZW'(42667331);
            5'd5:    r = ZW'(21354465);
            5'd6:    r = ZW'(10679838);
            5'd7:    r = ZW'(5340245);
            5'd8:    r = ZW'(2670163);
            5'd9:    r = ZW'(1335087);
            5'd10:   r = ZW'(667544);
            5'd11:   r = ZW'(333772);
            5'd12:   r = ZW'(166886);
            5'd13:   r = ZW'(83443);
            5'd14:   r = ZW'(41722);
            5'd15:   r = ZW'(20861);
            5'd16:   r = ZW'(10430);
            5'd17:   r = ZW'(5215);
            5'd18:   r = ZW'(2608);
            5'd19:   r = ZW'(1304);
            5'd20:   r = ZW'(652);
            5'd21:   r = ZW'(326);
            5'd22:   r = ZW'(163);
            5'd23:   r = ZW'(81);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/qte_front.sv
// Front end: component products, the atan2/asin operands and the radicand.
// Depends on qte_pkg.
module qte_front
    import qte_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 valid_in,
    input  logic signed [15:0]   q_w,
    input  logic signed [15:0]   q_x,
    input  logic signed [15:0]   q_y,
    input  logic signed [15:0]   q_z,
    output logic                 valid_out,
    output logic [RW-1:0]        rad,
    output qte_side_t            side
);

    logic [2:0] vld_reg;
    logic signed [31:0] ww_reg, wx_reg, wy_reg, wz_reg, xx_reg, xy_reg, xz_reg, yz_reg, zz_reg;
    qte_side_t s2_reg, s3_reg;
    logic [RW-1:0] rad_reg;

    logic signed [OPW+1:0] a_next;
    qte_side_t s2_next;
    logic signed [2*AW-1:0] sq_next;

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[1:0], valid_in};
    end

    // Stage 1: products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ww_reg <= q_w * q_w;
            wx_reg <= q_w * q_x;
            wy_reg <= q_w * q_y;
            wz_reg <= q_w * q_z;
            xx_reg <= q_x * q_x;
            xy_reg <= q_x * q_y;
            xz_reg <= q_x * q_z;
            yz_reg <= q_y * q_z;
            zz_reg <= q_z * q_z;
        end
    end

    // Stage 2: sums and clamp of the sine term
    always_comb
    begin
        s2_next.roll_y = OPW'(wx_reg) + OPW'(yz_reg);
        s2_next.roll_x = OPW'(ww_reg) + OPW'(zz_reg) - OPW'(64'sd536870912);
        s2_next.yaw_y  = OPW'(wz_reg) + OPW'(xy_reg);
        s2_next.yaw_x  = OPW'(ww_reg) + OPW'(xx_reg) - OPW'(64'sd536870912);
        a_next = (OPW+2)'(wy_reg) - (OPW+2)'(xz_reg);
        a_next = a_next <<< 1;
        s2_next.clamped = 1'b0;
        s2_next.sin_a = AW'(a_next);
        if (a_next > (OPW+2)'(64'sd1073741824))
        begin
            s2_next.sin_a   = AW'(64'sd1073741824);
            s2_next.clamped = 1'b1;
        end
        else if (a_next < -(OPW+2)'(64'sd1073741824))
        begin
            s2_next.sin_a   = -AW'(64'sd1073741824);
            s2_next.clamped = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s2_reg <= s2_next;
    end

    // Stage 3: radicand 2^60 - a*a
    assign sq_next = s2_reg.sin_a * s2_reg.sin_a;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg <= (RW'(1) << 60) - RW'(sq_next);
            s3_reg  <= s2_reg;
        end
    end

    assign valid_out = vld_reg[2];
    assign rad       = rad_reg;
    assign side      = s3_reg;

endmodule

FILE: rtl/core/qte_isqrt.sv
// Pipelined integer square root, one root bit per stage, with side payload.
// Depends on qte_pkg.
module qte_isqrt
    import qte_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 valid_in,
    input  logic [RW-1:0]        rad,
    input  qte_side_t            side_in,
    output logic                 valid_out,
    output logic [SQ_STEPS-1:0]  root,
    output qte_side_t            side_out
);

    logic [SQ_STEPS:0]     vld_reg;
    logic [RW-1:0]         rem_reg  [SQ_STEPS+1];
    logic [SQ_STEPS-1:0]   root_reg [SQ_STEPS+1];
    qte_side_t             side_reg [SQ_STEPS+1];

    assign vld_reg[0]  = valid_in;
    assign rem_reg[0]  = rad;
    assign root_reg[0] = '0;
    assign side_reg[0] = side_in;

    genvar g;
    generate
        for (g = 0; g < SQ_STEPS; g++)
        begin : g_step
            localparam int K = SQ_STEPS - 1 - g;
            logic [RW:0] delta;
            logic        take;

            // Try setting root bit K
            assign delta = ((RW+1)'(root_reg[g]) << (K + 1)) + ((RW+1)'(1) << (2 * K));
            assign take  = {1'b0, rem_reg[g]} >= delta;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[g+1] <= 1'b0;
                else if (en)
                    vld_reg[g+1] <= vld_reg[g];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[g+1]  <= take ? RW'({1'b0, rem_reg[g]} - delta) : rem_reg[g];
                    root_reg[g+1] <= take ? (root_reg[g] | (SQ_STEPS'(1) << K)) : root_reg[g];
                    side_reg[g+1] <= side_reg[g];
                end
            end
        end
    endgenerate

    assign valid_out = vld_reg[SQ_STEPS];
    assign root      = root_reg[SQ_STEPS];
    assign side_out  = side_reg[SQ_STEPS];

endmodule

FILE: rtl/core/qte_cordic.sv
// Pipelined vectoring CORDIC giving atan2(y, x) as a rounded binary angle.
// Depends on qte_pkg.
module qte_cordic
    import qte_pkg::*;
#(
    parameter int STEPS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    valid_in,
    input  logic signed [CW-1:0]    y_in,
    input  logic signed [CW-1:0]    x_in,
    output logic                    valid_out,
    output logic signed [ANG_W-1:0] angle
);

    localparam int N = (STEPS > ATAN_LEN) ? ATAN_LEN : STEPS;

    logic [N+1:0]          vld_reg;
    logic signed [CW-1:0]  x_reg [N+1];
    logic signed [CW-1:0]  y_reg [N+1];
    logic signed [ZW-1:0]  z_reg [N+1];
    logic [N:0]            zero_reg;
    logic signed [ANG_W-1:0] angle_reg;
    logic signed [ZW-1:0]  z_rnd;

    // Valid chain: pre-rotation, N iterations, rounding
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[N:0], valid_in};
    end

    // Turn a left half-plane vector into the right half plane
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            if (x_in[CW-1] && !y_in[CW-1])
            begin
                x_reg[0] <= y_in;
                y_reg[0] <= -x_in;
                z_reg[0] <= ZW'(64'sd1073741824);
            end
            else if (x_in[CW-1])
            begin
                x_reg[0] <= -y_in;
                y_reg[0] <= x_in;
                z_reg[0] <= -ZW'(64'sd1073741824);
            end
            else
            begin
                x_reg[0] <= x_in;
                y_reg[0] <= y_in;
                z_reg[0] <= '0;
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_iter
            logic signed [CW-1:0] dx, dy;
            logic signed [ZW-1:0] da;

            assign dx = y_reg[g] >>> g;
            assign dy = x_reg[g] >>> g;
            assign da = atan_ang(5'(g));

            // Rotate towards the x axis
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    zero_reg[g+1] <= zero_reg[g];
                    if (!y_reg[g][CW-1])
                    begin
                        x_reg[g+1] <= x_reg[g] + dx;
                        y_reg[g+1] <= y_reg[g] - dy;
                        z_reg[g+1] <= z_reg[g] + da;
                    end
                    else
                    begin
                        x_reg[g+1] <= x_reg[g] - dx;
                        y_reg[g+1] <= y_reg[g] + dy;
                        z_reg[g+1] <= z_reg[g] - da;
                    end
                end
            end
        end
    endgenerate

    // Round half up to pi = 2^15
    assign z_rnd = z_reg[N] + ZW'(32768);

    always_ff @(posedge clk)
    begin
        if (en)
            angle_reg <= zero_reg[N] ? '0 : ANG_W'(z_rnd >>> 16);
    end

    assign valid_out = vld_reg[N+1];
    assign angle     = angle_reg;

endmodule

FILE: rtl/core/quaternion_to_euler.sv
// Quaternion (Q1.15) to Z-Y-X Euler angles, top level.
// Depends on qte_pkg, qte_front, qte_isqrt and qte_cordic.
//
// Usage:
//   Input stream s_*: one quaternion per request, s_tdata = q_w, q_x, q_y, q_z
//   from bit 0 up, each signed Q1.15. Output stream m_*: roll, pitch, yaw as
//   signed binary angles (32768 = pi) in m_tdata, pitch_clamped in m_tuser.
//   Every request yields exactly one result, in order.
//   Throughput: one request per cycle while the output is taken.
//   Path from acceptance to m_tvalid: the front-end stages, the 31-stage
//   square-root pipeline (one root bit per stage), the CORDIC pre-rotation, one
//   CORDIC stage per iteration (CORDIC_STEPS capped at 24), rounding, output register.
//   Stall: when m_tvalid is high and m_tready low the whole pipeline holds
//   and s_tready drops; nothing is lost or repeated.
//   Reset: rst_n clears every valid bit; the data registers are not reset.
module quaternion_to_euler
    import qte_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // q_w[15:0], q_x[31:16], q_y[47:32], q_z[63:48]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // roll[15:0], pitch[31:16], yaw[47:32]
    output logic [0:0]  m_tuser    // pitch_clamped[0]
);

    localparam int N_C = ((CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS) + 2;

    logic                 adv;
    logic                 f_valid, s_valid, c_valid;
    logic [RW-1:0]        rad;
    qte_side_t            f_side, s_side, c_side_reg [N_C+1];
    logic [SQ_STEPS-1:0]  root;
    logic signed [ANG_W-1:0] roll_ang, pitch_ang, yaw_ang;
    logic                 m_tvalid_reg;
    logic [47:0]          m_tdata_reg;
    logic                 clamp_reg;
    logic signed [ANG_W-1:0] pitch_sat;

    // Advance everything unless a result waits untaken
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    qte_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .valid_in  (s_tvalid),
        .q_w       (s_tdata[15:0]),
        .q_x       (s_tdata[31:16]),
        .q_y       (s_tdata[47:32]),
        .q_z       (s_tdata[63:48]),
        .valid_out (f_valid),
        .rad       (rad),
        .side      (f_side)
    );

    qte_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .valid_in  (f_valid),
        .rad       (rad),
        .side_in   (f_side),
        .valid_out (s_valid),
        .root      (root),
        .side_out  (s_side)
    );

    qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .valid_in  (s_valid),
        .y_in      (CW'(s_side.roll_y)),
        .x_in      (CW'(s_side.roll_x)),
        .valid_out (),
        .angle     (roll_ang)
    );

    qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .valid_in  (s_valid),
        .y_in      (CW'(s_side.sin_a)),
        .x_in      (CW'({1'b0, root})),
        .valid_out (c_valid),
        .angle     (pitch_ang)
    );

    qte_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .valid_in  (s_valid),
        .y_in      (CW'(s_side.yaw_y)),
        .x_in      (CW'(s_side.yaw_x)),
        .valid_out (),
        .angle     (yaw_ang)
    );

    // Carry the clamp flag alongside the CORDIC stages
    assign c_side_reg[0] = s_side;
    genvar g;
    generate
        for (g = 0; g < N_C; g++)
        begin : g_flag
            always_ff @(posedge clk)
            begin
                if (adv)
                    c_side_reg[g+1] <= c_side_reg[g];
            end
        end
    endgenerate

    // Saturate pitch to plus or minus pi/2
    always_comb
    begin
        if (pitch_ang > PITCH_MAX)
            pitch_sat = PITCH_MAX;
        else if (pitch_ang < PITCH_MIN)
            pitch_sat = PITCH_MIN;
        else
            pitch_sat = pitch_ang;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (adv)
            m_tvalid_reg <= c_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_tdata_reg <= {yaw_ang[15:0], pitch_sat[15:0], roll_ang[15:0]};
            clamp_reg   <= c_side_reg[N_C].clamped;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = clamp_reg;

endmodule

FILE: rtl/core/qte_checker.sv
// Port-level checks for quaternion_to_euler, bound to the top level.
// Depends on quaternion_to_euler_macros.svh.
`include "quaternion_to_euler_macros.svh"

module qte_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // Hold a stalled result
    `QTE_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    // Accept input whenever the output register can move
    `QTE_ALWAYS(a_ready, s_tready == (!m_tvalid || m_tready))
    // Pitch within plus or minus pi/2
    `QTE_ALWAYS(a_pitch, !m_tvalid || ($signed(m_tdata[31:16]) <= 16'sd16384 && $signed(m_tdata[31:16]) >= -16'sd16384))
    // A presented result carries no unknown bits
    `QTE_ALWAYS(a_known, !m_tvalid || !$isunknown({m_tdata, m_tuser}))

endmodule

bind quaternion_to_euler qte_checker u_qte_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
